[hdl/tactile_frame_request_deframer_core_defines.svh]
// Assertion macros used by the checker file of the tactile frame deframer.
`ifndef TACTILE_FRAME_REQUEST_DEFRAMER_CORE_DEFINES_SVH
`define TACTILE_FRAME_REQUEST_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define TFRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define TFRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TFRD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/tfrd_pkg.sv]
// Shared types, codes and the command byte table of the tactile frame deframer.
package tfrd_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_REQ_LEN    = 2'd0;
  localparam logic [1:0] CFG_DEV_NUM    = 2'd1;
  localparam logic [1:0] CFG_TICK_LIMIT = 2'd2;

  // Register reset values.
  localparam logic [15:0] REQ_LEN_RESET    = 16'd717;
  localparam logic [7:0]  DEV_NUM_RESET    = 8'd0;
  localparam logic [15:0] TICK_LIMIT_RESET = 16'd100;

  // Default parameter values.
  localparam int PREFIX_BYTES_DEFAULT = 14;
  localparam int QUEUE_DEPTH_DEFAULT  = 4;

  // Frame header pair and counter limits.
  localparam logic [7:0]  HDR_FIRST     = 8'hAA;
  localparam logic [7:0]  HDR_SECOND    = 8'h55;
  localparam int          COUNT_W       = 17;
  localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  // Read command layout.
  localparam int CMD_LEN   = 14;
  localparam int CMD_POS_W = 4;
  // Byte sum of the fixed command bytes, modulo 256.
  localparam logic [7:0] CMD_FIXED_SUM = 8'h15;

  typedef enum logic [1:0] {
    KIND_CMD     = 2'd0,
    KIND_POINT   = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HUNT = 2'd1,
    PH_RECV = 2'd2
  } phase_t;

  // One queued job for the back end: a single result, or a whole command burst.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  force_x;
    logic [7:0]  force_y;
    logic [7:0]  force_z;
    logic [14:0] point_index;
    logic        last;
  } job_t;

  // Byte at a given position of the read command, with the LRC in the final slot.
  function automatic logic [7:0] cmd_byte(input logic [CMD_POS_W-1:0] pos,
                                          input logic [7:0] dev_num,
                                          input logic [15:0] req_len);
    logic [7:0] addr;
    logic [7:0] res;
    addr = dev_num + 8'd1;
    case (pos)
      4'd0:    res = 8'h55;
      4'd1:    res = 8'hAA;
      4'd2:    res = 8'h09;
      4'd4:    res = addr;
      4'd6:    res = 8'hFB;
      4'd7:    res = 8'h0E;
      4'd8:    res = 8'h04;
      4'd11:   res = req_len[7:0];
      4'd12:   res = req_len[15:8];
      4'd13:   res = 8'h00 - (CMD_FIXED_SUM + addr + req_len[7:0]
                              + req_len[15:8]);
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

[hdl/tactile_frame_request_deframer_core.sv]
// Top level of the tactile frame request deframer.
//
// Input stream (s_axis): one transaction per cycle while the job queue has room.
// tuser carries the operation (start request, received byte, millisecond tick),
// tdata the received byte. Output stream (m_axis): tuser carries the result kind
// (command byte, point, frame done, timeout), tlast marks the final command byte
// and the result that ends a frame. A start request produces the 14 read command
// bytes; a received byte or tick produces at most one result.
// Configuration: cfg_valid/cfg_ready write channel, always ready, index 0 is the
// payload length, 1 the module id, 2 the timeout in milliseconds; write only
// while the block is idle.
// An accepted input transaction is written into the job queue, then loaded into
// the output register, which drives m_axis_tvalid. Throughput: one input
// transaction per cycle while the job queue has room; the output register
// drains one result per cycle while the receiver is ready, so a start request
// holds the back end for its 14 command bytes. When the receiver stalls, the
// output register holds, the queue fills and s_axis_tready drops once it is full.
// Reset clears the frame state, the queue and the output valid, and loads the
// register defaults (length 717, module id 0, timeout 100 ms).
module tactile_frame_request_deframer_core import tfrd_pkg::*; #(
  parameter int PREFIX_BYTES = PREFIX_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] tx_byte, [15:8] force_x, [23:16] force_y,
                                      // [31:24] force_z, [46:32] point_index, [47] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] req_len;
  logic [7:0]  dev_num;
  logic [15:0] tick_limit;

  logic        push;
  job_t        push_job;
  logic        queue_full;
  logic        queue_empty;
  job_t        head_job;
  logic        pop;

  kind_t       out_kind;
  logic [7:0]  out_tx;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  logic [7:0]  out_z;
  logic [14:0] out_index;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_len    <= REQ_LEN_RESET;
      dev_num    <= DEV_NUM_RESET;
      tick_limit <= TICK_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REQ_LEN:    req_len    <= cfg_data;
        CFG_DEV_NUM:    dev_num    <= cfg_data[7:0];
        CFG_TICK_LIMIT: tick_limit <= cfg_data;
        default: begin
          // Index beyond the register list: write is dropped.
        end
      endcase
    end
  end

  tfrd_front #(
    .PREFIX_BYTES(PREFIX_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .op         (s_axis_tuser),
    .rx_byte    (s_axis_tdata),
    .req_len    (req_len),
    .tick_limit (tick_limit),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  tfrd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (queue_full),
    .empty    (queue_empty),
    .head     (head_job)
  );

  tfrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!queue_empty),
    .job       (head_job),
    .pop       (pop),
    .dev_num   (dev_num),
    .req_len   (req_len),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (out_kind),
    .out_tx    (out_tx),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_index (out_index),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {1'b0, out_index, out_z, out_y, out_x, out_tx};

endmodule

[hdl/tfrd_front.sv]
// Front end: accepts input transactions, tracks the frame and queues results.
module tfrd_front import tfrd_pkg::*; #(
  parameter int PREFIX_BYTES = PREFIX_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] req_len,
  input  logic [15:0] tick_limit,
  input  logic        queue_full,
  output logic        push,
  output job_t        job
);

  phase_t      phase, phase_next;
  logic        saw_first, saw_first_next;
  logic [16:0] frame_count, frame_count_next;
  logic [7:0]  pending_x, pending_x_next;
  logic [7:0]  pending_y, pending_y_next;
  logic [1:0]  trip_pos, trip_pos_next;
  logic [14:0] pt_counter, pt_counter_next;
  logic [15:0] elapsed, elapsed_next;

  logic        accept;
  logic [16:0] end_limit;
  logic [16:0] count_inc;
  logic [15:0] elapsed_inc;
  logic        point_hit;
  logic        end_hit;

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  assign end_limit = COUNT_W'(PREFIX_BYTES) + {1'b0, req_len};
  assign count_inc = (frame_count < COUNT_MAX) ? frame_count + 17'd1 : frame_count;
  assign elapsed_inc = (elapsed < ELAPSED_MAX) ? elapsed + 16'd1 : elapsed;

  // Frame state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      saw_first   <= 1'b0;
      frame_count <= '0;
      pending_x   <= '0;
      pending_y   <= '0;
      trip_pos    <= '0;
      pt_counter  <= '0;
      elapsed     <= '0;
    end else begin
      phase       <= phase_next;
      saw_first   <= saw_first_next;
      frame_count <= frame_count_next;
      pending_x   <= pending_x_next;
      pending_y   <= pending_y_next;
      trip_pos    <= trip_pos_next;
      pt_counter  <= pt_counter_next;
      elapsed     <= elapsed_next;
    end
  end

  // Classify each accepted transaction and decide what result it queues.
  always_comb begin
    phase_next       = phase;
    saw_first_next   = saw_first;
    frame_count_next = frame_count;
    pending_x_next   = pending_x;
    pending_y_next   = pending_y;
    trip_pos_next    = trip_pos;
    pt_counter_next  = pt_counter;
    elapsed_next     = elapsed;
    push             = 1'b0;
    job              = '0;
    point_hit        = 1'b0;
    end_hit          = 1'b0;
    if (accept) begin
      unique case (op)
        OP_START: begin
          // A new request abandons any frame in progress.
          push             = 1'b1;
          job.kind         = KIND_CMD;
          phase_next       = PH_HUNT;
          saw_first_next   = 1'b0;
          frame_count_next = '0;
          pending_x_next   = '0;
          pending_y_next   = '0;
          trip_pos_next    = '0;
          pt_counter_next  = '0;
          elapsed_next     = '0;
        end
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= tick_limit) begin
              push       = 1'b1;
              job.kind   = KIND_TIMEOUT;
              job.last   = 1'b1;
              phase_next = PH_IDLE;
            end
          end
        end
        OP_BYTE: begin
          if (phase == PH_HUNT) begin
            if (saw_first && rx_byte == HDR_SECOND) begin
              // Header pair found: the frame count includes both header bytes.
              phase_next       = PH_RECV;
              frame_count_next = 17'd2;
              saw_first_next   = 1'b0;
              end_hit          = (17'd2 >= end_limit);
            end else begin
              saw_first_next = (rx_byte == HDR_FIRST);
            end
          end else if (phase == PH_RECV) begin
            frame_count_next = count_inc;
            if (count_inc > COUNT_W'(PREFIX_BYTES)) begin
              case (trip_pos)
                2'd0: begin
                  pending_x_next = rx_byte;
                  trip_pos_next  = 2'd1;
                end
                2'd1: begin
                  pending_y_next = rx_byte;
                  trip_pos_next  = 2'd2;
                end
                default: begin
                  point_hit       = 1'b1;
                  pt_counter_next = pt_counter + 15'd1;
                  trip_pos_next   = 2'd0;
                end
              endcase
            end
            end_hit = (count_inc >= end_limit);
          end
          if (point_hit) begin
            push            = 1'b1;
            job.kind        = KIND_POINT;
            job.force_x     = pending_x;
            job.force_y     = pending_y;
            job.force_z     = rx_byte;
            job.point_index = pt_counter;
            job.last        = end_hit;
          end else if (end_hit) begin
            push     = 1'b1;
            job.kind = KIND_DONE;
            job.last = 1'b1;
          end
          if (end_hit) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          // Unused operation code: no effect.
        end
      endcase
    end
  end

endmodule

[hdl/tfrd_queue.sv]
// Short job queue between the front end and the back end.
module tfrd_queue import tfrd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t            slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

[hdl/tfrd_back.sv]
// Back end: expands command jobs into bytes and drives the output register.
module tfrd_back import tfrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        pop,
  input  logic [7:0]  dev_num,
  input  logic [15:0] req_len,
  output logic        out_valid,
  input  logic        out_ready,
  output kind_t       out_kind,
  output logic [7:0]  out_tx,
  output logic [7:0]  out_x,
  output logic [7:0]  out_y,
  output logic [7:0]  out_z,
  output logic [14:0] out_index,
  output logic        out_last
);

  logic                 load;
  logic                 cmd_active;
  logic [CMD_POS_W-1:0] cmd_pos;
  logic                 cmd_end;

  assign load    = !out_valid || out_ready;
  assign pop     = load && !cmd_active && job_valid;
  assign cmd_end = (cmd_pos == CMD_POS_W'(CMD_LEN - 1));

  // Output valid and command burst sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      cmd_active <= 1'b0;
      cmd_pos    <= '0;
    end else if (load) begin
      if (cmd_active) begin
        out_valid  <= 1'b1;
        cmd_active <= !cmd_end;
        cmd_pos    <= cmd_pos + CMD_POS_W'(1);
      end else if (job_valid) begin
        out_valid <= 1'b1;
        if (job.kind == KIND_CMD) begin
          cmd_active <= 1'b1;
          cmd_pos    <= CMD_POS_W'(1);
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      if (cmd_active) begin
        out_kind  <= KIND_CMD;
        out_tx    <= cmd_byte(cmd_pos, dev_num, req_len);
        out_x     <= '0;
        out_y     <= '0;
        out_z     <= '0;
        out_index <= '0;
        out_last  <= cmd_end;
      end else if (job_valid) begin
        out_kind  <= job.kind;
        out_tx    <= (job.kind == KIND_CMD) ? cmd_byte('0, dev_num, req_len) : 8'h00;
        out_x     <= job.force_x;
        out_y     <= job.force_y;
        out_z     <= job.force_z;
        out_index <= job.point_index;
        out_last  <= job.last;
      end
    end
  end

endmodule

[hdl/tfrd_checker.sv]
// Port-level checks for the tactile frame deframer, bound to the top level.
`include "tactile_frame_request_deframer_core_defines.svh"

module tfrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result holds its valid and payload.
  `TFRD_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
    "stalled output changed")

  // The input side only backs up when a result is waiting on the output.
  `TFRD_ASSERT_NOW(a_backpressure, clk, rst, !s_axis_tready, m_axis_tvalid,
    "input stalled with empty output")

  // Reset leaves no result on the output.
  `TFRD_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, rst, !m_axis_tvalid, "output valid after reset")

  // Configuration port never stalls.
  `TFRD_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind tactile_frame_request_deframer_core tfrd_checker u_checker (.*);

[dv/tactile_frame_request_deframer_core_test.sv]
// Self-checking testbench for the tactile frame request deframer core.
module tactile_frame_request_deframer_core_test;
  import tfrd_pkg::*;

  localparam int         FRAME_PREFIX = PREFIX_BYTES_DEFAULT;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  // One result as it leaves the block, split into its fields.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic [7:0]  force_x;
    logic [7:0]  force_y;
    logic [7:0]  force_z;
    logic [14:0] point_index;
    logic        last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic [1:0]  s_axis_tuser = OP_UNUSED; // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;           // [7:0] tx_byte, [15:8] force_x, [23:16] force_y,
                                       // [31:24] force_z, [46:32] point_index, [47] zero
  logic [1:0]  m_axis_tuser;           // [1:0] kind
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_REQ_LEN;
  logic [15:0] cfg_data = 16'h0000;

  // Register copies used by the prediction.
  logic [15:0] cfg_length     = REQ_LEN_RESET;
  logic [7:0]  cfg_module     = DEV_NUM_RESET;
  logic [15:0] cfg_tick_limit = TICK_LIMIT_RESET;

  // Frame tracking state of the prediction.
  phase_t      frame_phase    = PH_IDLE;
  logic        hdr_first_seen = 1'b0;
  logic [16:0] frame_bytes    = '0;
  logic [7:0]  held_x         = '0;
  logic [7:0]  held_y         = '0;
  logic [1:0]  triplet_slot   = '0;
  logic [14:0] pt_seq         = '0;
  logic [15:0] ms_elapsed     = '0;

  frame_result_t results_due[$];
  int            handled_items = 0;
  int            mismatches    = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  tactile_frame_request_deframer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Works out the results of one accepted input transaction and queues them.
  function automatic void deframe_item(input logic [1:0] op, input logic [7:0] rx);
    logic [7:0]    cmd [0:13];
    logic [7:0]    sum;
    frame_result_t res;
    logic          have_point;
    res = '0;
    have_point = 1'b0;
    if (op == OP_START || (op != OP_UNUSED && frame_phase != PH_IDLE)) handled_items++;
    case (op)
      OP_START: begin
        cmd = '{8'h55, 8'hAA, 8'h09, 8'h00, cfg_module + 8'd1, 8'h00, 8'hFB, 8'h0E,
                8'h04, 8'h00, 8'h00, cfg_length[7:0], cfg_length[15:8], 8'h00};
        sum = 8'h00;
        for (int i = 0; i < 13; i++) sum += cmd[i];
        cmd[13] = 8'h00 - sum;
        for (int i = 0; i < 14; i++) begin
          res = '0;
          res.kind = KIND_CMD;
          res.tx_byte = cmd[i];
          res.last = (i == 13);
          results_due = {results_due, res};
        end
        hdr_first_seen = 1'b0;
        frame_bytes = '0;
        held_x = '0;
        held_y = '0;
        triplet_slot = '0;
        pt_seq = '0;
        ms_elapsed = '0;
        frame_phase = PH_HUNT;
      end
      OP_TICK: begin
        if (frame_phase != PH_IDLE) begin
          if (ms_elapsed != ELAPSED_MAX) ms_elapsed++;
          if (ms_elapsed >= cfg_tick_limit) begin
            res.kind = KIND_TIMEOUT;
            res.last = 1'b1;
            results_due = {results_due, res};
            frame_phase = PH_IDLE;
          end
        end
      end
      OP_BYTE: begin
        if (frame_phase == PH_HUNT) begin
          if (hdr_first_seen && rx == HDR_SECOND) begin
            frame_phase = PH_RECV;
            frame_bytes = 17'd2;
            hdr_first_seen = 1'b0;
          end else begin
            hdr_first_seen = (rx == HDR_FIRST);
          end
        end else if (frame_phase == PH_RECV) begin
          if (frame_bytes != COUNT_MAX) frame_bytes++;
          if (frame_bytes > FRAME_PREFIX) begin
            // Payload bytes come as x, y, z; the z byte completes a point.
            case (triplet_slot)
              2'd0: begin
                held_x = rx;
                triplet_slot = 2'd1;
              end
              2'd1: begin
                held_y = rx;
                triplet_slot = 2'd2;
              end
              default: begin
                res.kind = KIND_POINT;
                res.force_x = held_x;
                res.force_y = held_y;
                res.force_z = rx;
                res.point_index = pt_seq;
                have_point = 1'b1;
                pt_seq++;
                triplet_slot = 2'd0;
              end
            endcase
          end
          // The frame ends once the byte count reaches or passes its length.
          if (int'(frame_bytes) >= FRAME_PREFIX + int'(cfg_length)) begin
            if (!have_point) begin
              res = '0;
              res.kind = KIND_DONE;
              have_point = 1'b1;
            end
            res.last = 1'b1;
            frame_phase = PH_IDLE;
          end
          if (have_point) results_due = {results_due, res};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver side: random stalls per the current idling phase.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare every output transaction with the oldest expected result.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0d, tdata 0x%0h, tlast %0b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
        check_field("tx_byte", 16'(want.tx_byte), 16'(m_axis_tdata[7:0]));
        check_field("force_x", 16'(want.force_x), 16'(m_axis_tdata[15:8]));
        check_field("force_y", 16'(want.force_y), 16'(m_axis_tdata[23:16]));
        check_field("force_z", 16'(want.force_z), 16'(m_axis_tdata[31:24]));
        check_field("point_index", 16'(want.point_index), 16'(m_axis_tdata[46:32]));
        check_field("last", 16'(want.last), 16'(m_axis_tlast));
      end
    end
  end

  // Sends one input transaction, then idles at random.
  task automatic send_item(input logic [1:0] op, input logic [7:0] rx);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= rx;
    do @(posedge clk); while (!s_axis_tready);
    deframe_item(op, rx);
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender until every expected result has come and the pipeline is empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Writes all three registers once the block has gone quiet.
  task automatic configure(input logic [15:0] length, input logic [15:0] module_value,
                           input logic [15:0] tmo);
    logic [1:0]  regs [0:2];
    logic [15:0] values [0:2];
    regs = '{CFG_REQ_LEN, CFG_DEV_NUM, CFG_TICK_LIMIT};
    values = '{length, module_value, tmo};
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= values[i];
      do @(posedge clk); while (!cfg_ready);
      case (regs[i])
        CFG_REQ_LEN:    cfg_length = values[i];
        CFG_DEV_NUM:    cfg_module = values[i][7:0];
        CFG_TICK_LIMIT: cfg_tick_limit = values[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_header();
    send_item(OP_BYTE, HDR_FIRST);
    send_item(OP_BYTE, HDR_SECOND);
  endtask

  task automatic send_random_bytes(input int count);
    repeat (count) send_item(OP_BYTE, 8'($urandom));
  endtask

  // Bytes, ticks and the unused code while idle produce nothing.
  task automatic test_idle_items();
    send_item(OP_BYTE, HDR_FIRST);
    send_item(OP_TICK, 8'h00);
    send_item(OP_UNUSED, 8'hFF);
    settle();
  endtask

  // Read command with the register defaults; the unused code while busy is ignored.
  task automatic test_reset_command();
    send_item(OP_START, 8'h00);
    send_item(OP_UNUSED, 8'h00);
    settle();
  endtask

  // Largest length, module ids 254 and 255, timeouts 0 and 1: each request times out on its first tick.
  task automatic test_timeout_zero();
    configure(16'hFFFF, 16'hFF00 | 16'd254, 16'd0);
    send_item(OP_START, 8'hFF);
    send_item(OP_TICK, 8'h5A);
    configure(16'hFFFF, 16'd255, 16'd1);
    send_item(OP_START, 8'h00);
    send_item(OP_TICK, 8'hA5);
  endtask

  // Header hunt with a false start, extreme point values, then the length lowered mid-frame.
  task automatic test_point_stream();
    configure(16'd7, 16'd255, 16'hFFFF);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, HDR_SECOND);
    send_item(OP_BYTE, HDR_FIRST);
    send_header();
    // Header bytes inside the prefix must be skipped.
    for (int i = 0; i < FRAME_PREFIX - 2; i++)
      send_item(OP_BYTE, (i % 2) ? HDR_SECOND : HDR_FIRST);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_BYTE, 8'hFF);
    configure(16'd3, 16'd255, 16'hFFFF);
    send_item(OP_BYTE, 8'h7F);
  endtask

  // Zero payload length: the done result comes with the last prefix byte.
  task automatic test_empty_payload();
    configure(16'd0, 16'd0, 16'd50);
    send_item(OP_START, 8'h00);
    send_header();
    send_random_bytes(FRAME_PREFIX - 2);
  endtask

  // Start while hunting restarts the request; the final point carries last.
  task automatic test_restart_last_point();
    configure(16'd3, 16'd1, 16'd2);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, HDR_FIRST);
    send_item(OP_START, 8'h00);
    send_header();
    send_random_bytes(FRAME_PREFIX - 2);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, 8'h00);
    settle();
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 5))
      0:       send_item(OP_TICK, 8'($urandom));
      1:       send_item(OP_UNUSED, 8'($urandom));
      default: send_item(OP_BYTE, 8'($urandom));
    endcase
  endtask

  // New register setting: mostly short frames, sometimes very long ones with a short timeout.
  task automatic random_config();
    logic [15:0] length;
    logic [15:0] tmo;
    logic [15:0] module_value;
    case ($urandom_range(0, 9))
      0:       length = 16'($urandom_range(41, 65535));
      1:       length = 16'hFFFF;
      2, 3:    length = 16'($urandom_range(13, 40));
      default: length = 16'($urandom_range(0, 12));
    endcase
    if (length > 40 || $urandom_range(0, 2) == 0) tmo = 16'($urandom_range(1, 30));
    else tmo = 16'($urandom_range(1000, 65535));
    module_value = 16'($urandom);
    if ($urandom_range(0, 4) == 0) module_value[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    configure(length, module_value, tmo);
  endtask

  // One request: noise, the header pair, prefix and payload with ticks mixed in.
  task automatic random_frame();
    int body;
    int cut;
    send_item(OP_START, 8'($urandom));
    repeat ($urandom_range(0, 3)) send_noise();
    if ($urandom_range(0, 9) != 0) send_header();
    if (cfg_length > 40) body = $urandom_range(0, 40);
    else body = FRAME_PREFIX - 2 + int'(cfg_length) + $urandom_range(0, 2);
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, body) : body;
    for (int i = 0; i < cut && frame_phase != PH_IDLE; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, 8'($urandom));
    end
    // Run a stuck request into its timeout when that is close enough.
    while (frame_phase != PH_IDLE && int'(cfg_tick_limit) - int'(ms_elapsed) < 48)
      send_item(OP_TICK, 8'($urandom));
    if ($urandom_range(0, 3) == 0) send_noise();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int target;
    settle();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = handled_items + count;
    while (handled_items < target) begin
      if ($urandom_range(0, 2) == 0) random_config();
      random_frame();
    end
  endtask

  // Run limit.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_items();
    test_reset_command();
    test_timeout_zero();
    test_point_stream();
    test_empty_payload();
    test_restart_last_point();
    test_random_traffic(0, 0, 62);
    test_random_traffic(75, 0, 62);
    test_random_traffic(0, 75, 62);
    test_random_traffic(19, 19, 62);
    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
